// File: hdl/rna_pkg.sv
// Package for the rational number ALU: field widths, operation and status codes,
// the queued transaction type and the back-end sequencer states.
// Depends on nothing; every other file of the block uses it.
package rna_pkg;

	// Default datapath width and fixed port field widths.
	localparam int WordBits   = 32;
	localparam int FieldBits  = 32;
	localparam int DenBits    = 31;
	localparam int QueueDepth = 2;

	// Operation codes; code 7 is treated as a reduce.
	typedef enum logic [2:0] {
		K_ADD   = 3'd0,
		K_SUB   = 3'd1,
		K_MUL   = 3'd2,
		K_DIV   = 3'd3,
		K_NEG   = 3'd4,
		K_RECIP = 3'd5,
		K_RED   = 3'd6
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// One classified transaction as it waits between front and back.
	typedef struct packed {
		logic [2:0]                  kind;
		logic                        binary;
		logic                        div0;
		logic signed [FieldBits-1:0] a_num;
		logic signed [FieldBits-1:0] a_den;
		logic signed [FieldBits-1:0] b_num;
		logic signed [FieldBits-1:0] b_den;
	} item_t;

	// Handshake toward the queue.
	typedef struct packed {
		logic  valid;
		item_t data;
	} push_t;

	// Which pair the shared reduction is working on.
	typedef enum logic [1:0] {
		PASS_A = 2'd0,
		PASS_B = 2'd1,
		PASS_R = 2'd2
	} pass_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		BK_IDLE  = 4'd0,
		BK_GINIT = 4'd1,
		BK_GCD   = 4'd2,
		BK_DIVN  = 4'd3,
		BK_DIVD  = 4'd4,
		BK_FIX   = 4'd5,
		BK_CHECK = 4'd6,
		BK_MUL   = 4'd7,
		BK_FORM  = 4'd8,
		BK_DONE  = 4'd9
	} back_state_t;

endpackage

// File: hdl/rna_if.sv
// Channel interfaces of the rational number ALU: operand and result transactions.
// Depends on rna_pkg for the field widths.
interface rna_opnd_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           kind;
	logic signed [rna_pkg::FieldBits-1:0] a_num;
	logic signed [rna_pkg::FieldBits-1:0] a_den;
	logic signed [rna_pkg::FieldBits-1:0] b_num;
	logic signed [rna_pkg::FieldBits-1:0] b_den;

	modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rna_pkg::FieldBits-1:0] res_num;
	logic [rna_pkg::DenBits-1:0]          res_den;
	logic [1:0]                           status;

	modport source (output valid, res_num, res_den, status, input ready);
	modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// File: hdl/rational_number_alu.sv
// Top level of the rational number ALU: front end, queue and back end.
// Depends on rna_pkg, rna_if, rna_front, rna_queue and rna_back.
//
//  Channel | Direction | Fields                                 | Handshake
//  opnd    | in        | kind, a_num, a_den, b_num, b_den       | valid/ready
//  result  | out       | res_num, res_den, status               | valid/ready
//
// Each reduction of a pair runs the GCD setup, the binary GCD of at most about
// 4*WORD_BITS steps, two WORD_BITS-step restoring divisions and the sign fix.
// Binary operations reduce three pairs and unary ones two. A transaction also
// passes through pop, zero-divisor check, three multiplies, forming and result
// hand-off. An overflowing operand or a zero divisor ends the transaction early.
// Zero-denominator transactions go straight from pop to result hand-off. Reset is
// asynchronous and needs no clearing pass. The two-entry queue keeps taking
// operands until it is full while the back end works or while a finished result
// waits for its sink.
module rational_number_alu #(
	parameter int WORD_BITS = rna_pkg::WordBits
) (
	input  logic         clk,
	input  logic         arst_n,
	rna_opnd_if.sink     opnd,
	rna_result_if.source result
);

	rna_pkg::push_t push;
	logic           push_ready;
	logic           pop_valid;
	rna_pkg::item_t pop_data;
	logic           pop_ready;

	// Classify incoming transactions.
	rna_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.opnd       (opnd),
		.push       (push),
		.push_ready (push_ready)
	);

	// Decouple front and back.
	rna_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// Carry out the arithmetic and reduction.
	rna_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

// File: hdl/rna_front.sv
// Front end of the rational number ALU: accepts operand transactions, flags
// zero denominators and unary/binary kinds, and pushes them to the queue.
// Depends on rna_pkg and rna_if.
module rna_front #(
	parameter int WORD_BITS = rna_pkg::WordBits
) (
	rna_opnd_if.sink       opnd,
	output rna_pkg::push_t push,
	input  logic           push_ready
);

	logic binary;
	logic ad_zero;
	logic bd_zero;

	// Classify the kind and look for zero denominators in the used bits.
	always_comb begin
		binary  = (opnd.kind == rna_pkg::K_ADD) || (opnd.kind == rna_pkg::K_SUB) ||
		          (opnd.kind == rna_pkg::K_MUL) || (opnd.kind == rna_pkg::K_DIV);
		ad_zero = (opnd.a_den[WORD_BITS-1:0] == '0);
		bd_zero = (opnd.b_den[WORD_BITS-1:0] == '0);
	end

	// Build the queued transaction.
	always_comb begin
		push.valid       = opnd.valid;
		push.data.kind   = opnd.kind;
		push.data.binary = binary;
		push.data.div0   = ad_zero || (binary && bd_zero);
		push.data.a_num  = opnd.a_num;
		push.data.a_den  = opnd.a_den;
		push.data.b_num  = opnd.b_num;
		push.data.b_den  = opnd.b_den;
		opnd.ready       = push_ready;
	end

endmodule

// File: hdl/rna_queue.sv
// Short queue between front and back end of the rational number ALU.
// Depends on rna_pkg for the transaction type and depth.
module rna_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rna_pkg::push_t push,
	output logic           push_ready,
	output logic           pop_valid,
	output rna_pkg::item_t pop_data,
	input  logic           pop_ready
);

	localparam int PtrBits = (rna_pkg::QueueDepth > 1) ? $clog2(rna_pkg::QueueDepth) : 1;
	localparam int CntBits = $clog2(rna_pkg::QueueDepth + 1);

	rna_pkg::item_t         slot_q [rna_pkg::QueueDepth];
	logic [PtrBits-1:0]     wr_ptr_q;
	logic [PtrBits-1:0]     rd_ptr_q;
	logic [CntBits-1:0]     count_q;
	logic                   do_push;
	logic                   do_pop;

	// Flow control.
	always_comb begin
		push_ready = (count_q != CntBits'(rna_pkg::QueueDepth));
		pop_valid  = (count_q != '0);
		pop_data   = slot_q[rd_ptr_q];
		do_push    = push.valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(rna_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(rna_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.data;
		end
	end

endmodule

// File: hdl/rna_back.sv
// Back end of the rational number ALU: sequencer with a binary GCD unit, a
// restoring divider and one shared multiplier. Depends on rna_pkg and rna_if.
module rna_back #(
	parameter int WORD_BITS = rna_pkg::WordBits
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  rna_pkg::item_t pop_data,
	output logic           pop_ready,
	rna_result_if.source   result
);

	localparam int W   = WORD_BITS;
	localparam int KB  = $clog2(W);
	localparam int SW  = 2 * W + 1;

	rna_pkg::back_state_t state_q, state_d;
	rna_pkg::pass_t       pass_q;
	rna_pkg::item_t       item_q;

	logic signed [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic signed [W-1:0]  rn_q, rd_q;
	logic [W-1:0]         gu_q, gv_q, g_q;
	logic [KB-1:0]        gk_q;
	logic [W:0]           rem_q;
	logic [W-1:0]         quo_q;
	logic [KB-1:0]        cnt_q;
	logic [W-1:0]         qn_q, qd_q;
	logic [1:0]           mcnt_q;
	logic signed [2*W-1:0] p0_q, p1_q, p2_q;
	logic signed [rna_pkg::FieldBits-1:0] res_num_q;
	logic [rna_pkg::DenBits-1:0]          res_den_q;
	rna_pkg::status_t     status_q;

	logic [W-1:0]         mag_n, mag_d;
	logic                 gcd_done;
	logic [W-1:0]         g_raw, g_val;
	logic [W:0]           rem_sh;
	logic                 rem_ge;
	logic [W:0]           rem_next;
	logic [W-1:0]         quo_next;
	logic                 div_last;
	logic                 fix_neg, fix_ok;
	logic signed [W-1:0]  fix_n;
	logic signed [W-1:0]  mul_a, mul_b;
	logic signed [2*W-1:0] mul_p;
	logic signed [SW-1:0] sn, sd;
	logic                 sn_ok, sd_ok;
	logic                 zero_div;
	logic                 is_div, is_mul, is_sub, is_add, is_neg, is_recip;

	// Decode of the held kind.
	always_comb begin
		is_add   = (item_q.kind == rna_pkg::K_ADD);
		is_sub   = (item_q.kind == rna_pkg::K_SUB);
		is_mul   = (item_q.kind == rna_pkg::K_MUL);
		is_div   = (item_q.kind == rna_pkg::K_DIV);
		is_neg   = (item_q.kind == rna_pkg::K_NEG);
		is_recip = (item_q.kind == rna_pkg::K_RECIP);
		zero_div = (is_div && bn_q == '0) || (is_recip && an_q == '0);
	end

	// Magnitudes of the pair under reduction and the binary GCD result.
	always_comb begin
		mag_n    = rn_q[W-1] ? (~rn_q + 1'b1) : rn_q;
		mag_d    = rd_q[W-1] ? (~rd_q + 1'b1) : rd_q;
		gcd_done = (gu_q == '0) || (gv_q == '0);
		g_raw    = ((gu_q == '0) ? gv_q : gu_q) << gk_q;
		g_val    = (g_raw == '0) ? W'(1) : g_raw;
	end

	// One restoring division step.
	always_comb begin
		rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
		rem_ge   = (rem_sh >= {1'b0, g_q});
		rem_next = rem_ge ? (rem_sh - {1'b0, g_q}) : rem_sh;
		quo_next = {quo_q[W-2:0], rem_ge};
		div_last = (cnt_q == KB'(W - 1));
	end

	// Sign fix and range check of the reduced pair.
	always_comb begin
		fix_neg = rn_q[W-1] ^ rd_q[W-1];
		fix_ok  = !qd_q[W-1] && (fix_neg || !qn_q[W-1]);
		fix_n   = fix_neg ? (~qn_q + 1'b1) : qn_q;
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (mcnt_q)
			2'd0: begin
				mul_a = an_q;
				mul_b = is_mul ? bn_q : bd_q;
			end
			2'd1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = is_div ? bn_q : bd_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Raw result pair and its range check.
	always_comb begin
		if (is_add) begin
			sn = SW'(p0_q) + SW'(p1_q);
			sd = SW'(p2_q);
		end else if (is_sub) begin
			sn = SW'(p0_q) - SW'(p1_q);
			sd = SW'(p2_q);
		end else if (is_mul || is_div) begin
			sn = SW'(p0_q);
			sd = SW'(p2_q);
		end else if (is_neg) begin
			sn = -SW'(an_q);
			sd = SW'(ad_q);
		end else if (is_recip) begin
			sn = SW'(ad_q);
			sd = SW'(an_q);
		end else begin
			sn = SW'(an_q);
			sd = SW'(ad_q);
		end
		sn_ok = (&sn[SW-1:W-1]) || !(|sn[SW-1:W-1]);
		sd_ok = (&sd[SW-1:W-1]) || !(|sd[SW-1:W-1]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rna_pkg::BK_IDLE: begin
				if (pop_valid) begin
					state_d = pop_data.div0 ? rna_pkg::BK_DONE : rna_pkg::BK_GINIT;
				end
			end
			rna_pkg::BK_GINIT: state_d = rna_pkg::BK_GCD;
			rna_pkg::BK_GCD: begin
				if (gcd_done) begin
					state_d = rna_pkg::BK_DIVN;
				end
			end
			rna_pkg::BK_DIVN: begin
				if (div_last) begin
					state_d = rna_pkg::BK_DIVD;
				end
			end
			rna_pkg::BK_DIVD: begin
				if (div_last) begin
					state_d = rna_pkg::BK_FIX;
				end
			end
			rna_pkg::BK_FIX: begin
				if (!fix_ok || pass_q == rna_pkg::PASS_R) begin
					state_d = rna_pkg::BK_DONE;
				end else if (pass_q == rna_pkg::PASS_A && item_q.binary) begin
					state_d = rna_pkg::BK_GINIT;
				end else begin
					state_d = rna_pkg::BK_CHECK;
				end
			end
			rna_pkg::BK_CHECK: state_d = zero_div ? rna_pkg::BK_DONE : rna_pkg::BK_MUL;
			rna_pkg::BK_MUL: begin
				if (mcnt_q == 2'd2) begin
					state_d = rna_pkg::BK_FORM;
				end
			end
			rna_pkg::BK_FORM: state_d = (sn_ok && sd_ok) ? rna_pkg::BK_GINIT : rna_pkg::BK_DONE;
			rna_pkg::BK_DONE: begin
				if (result.ready) begin
					state_d = rna_pkg::BK_IDLE;
				end
			end
			default: state_d = rna_pkg::BK_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		pop_ready      = (state_q == rna_pkg::BK_IDLE);
		result.valid   = (state_q == rna_pkg::BK_DONE);
		result.res_num = res_num_q;
		result.res_den = res_den_q;
		result.status  = status_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rna_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers, loaded per state.
	always_ff @(posedge clk) begin
		case (state_q)
			rna_pkg::BK_IDLE: begin
				item_q    <= pop_data;
				pass_q    <= rna_pkg::PASS_A;
				rn_q      <= pop_data.a_num[W-1:0];
				rd_q      <= pop_data.a_den[W-1:0];
				res_num_q <= '0;
				res_den_q <= '0;
				status_q  <= rna_pkg::ST_DIV0;
			end
			rna_pkg::BK_GINIT: begin
				gu_q <= mag_n;
				gv_q <= mag_d;
				gk_q <= '0;
			end
			rna_pkg::BK_GCD: begin
				if (gcd_done) begin
					g_q   <= g_val;
					rem_q <= '0;
					quo_q <= mag_n;
					cnt_q <= '0;
				end else if (!gu_q[0] && !gv_q[0]) begin
					gu_q <= gu_q >> 1;
					gv_q <= gv_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!gu_q[0]) begin
					gu_q <= gu_q >> 1;
				end else if (!gv_q[0]) begin
					gv_q <= gv_q >> 1;
				end else if (gu_q >= gv_q) begin
					gu_q <= gu_q - gv_q;
				end else begin
					gv_q <= gv_q - gu_q;
				end
			end
			rna_pkg::BK_DIVN: begin
				if (div_last) begin
					qn_q  <= quo_next;
					rem_q <= '0;
					quo_q <= mag_d;
					cnt_q <= '0;
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			rna_pkg::BK_DIVD: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					qd_q <= quo_next;
				end
			end
			rna_pkg::BK_FIX: begin
				if (!fix_ok) begin
					status_q <= rna_pkg::ST_OVF;
				end else begin
					case (pass_q)
						rna_pkg::PASS_A: begin
							an_q   <= fix_n;
							ad_q   <= qd_q;
							pass_q <= rna_pkg::PASS_B;
							rn_q   <= item_q.b_num[W-1:0];
							rd_q   <= item_q.b_den[W-1:0];
						end
						rna_pkg::PASS_B: begin
							bn_q <= fix_n;
							bd_q <= qd_q;
						end
						default: begin
							res_num_q <= rna_pkg::FieldBits'(fix_n);
							res_den_q <= rna_pkg::DenBits'(qd_q[W-2:0]);
							status_q  <= rna_pkg::ST_OK;
						end
					endcase
				end
			end
			rna_pkg::BK_CHECK: begin
				mcnt_q   <= '0;
				status_q <= rna_pkg::ST_DIV0;
			end
			rna_pkg::BK_MUL: begin
				case (mcnt_q)
					2'd0:    p0_q <= mul_p;
					2'd1:    p1_q <= mul_p;
					default: p2_q <= mul_p;
				endcase
				mcnt_q <= mcnt_q + 1'b1;
			end
			rna_pkg::BK_FORM: begin
				rn_q     <= sn[W-1:0];
				rd_q     <= sd[W-1:0];
				pass_q   <= rna_pkg::PASS_R;
				status_q <= rna_pkg::ST_OVF;
			end
			default: begin
			end
		endcase
	end

endmodule
